>>> rtl/core/iptj_pkg.sv
// Package for the I/O page timer and joypad port.
// Holds the word types, operation codes and address map constants.
// No dependencies.
package iptj_pkg;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	localparam logic [2:0] REGION_TIMER  = 3'b011;
	localparam logic [2:0] REGION_JOYPAD = 3'b100;
	localparam logic [7:0] RELOAD_MASK   = 8'h7f;

	typedef struct packed {
		logic [1:0]  operation;
		logic [12:0] offset;
		logic [7:0]  write_data;
		logic [7:0]  buttons;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       timer_irq;
	} result_t;

endpackage

>>> rtl/core/iptj_ifs.sv
// Valid/ready channel interfaces for the I/O page timer and joypad port.
// Request, response and configuration channels. No dependencies.
interface iptj_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [12:0] offset;
	logic [7:0]  write_data;
	logic [7:0]  buttons;
	modport source (output valid, operation, offset, write_data, buttons, input ready);
	modport sink   (input valid, operation, offset, write_data, buttons, output ready);
endinterface

interface iptj_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       timer_irq;
	modport source (output valid, read_data, timer_irq, input ready);
	modport sink   (input valid, read_data, timer_irq, output ready);
endinterface

interface iptj_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

>>> rtl/core/iptj_core.sv
// Timer, status, preload and nibble select registers with the bus decode.
// Computes one result word per executed item. Depends on iptj_pkg.
module iptj_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             exec,
	input  iptj_pkg::item_t  item,
	input  logic             country,
	output iptj_pkg::result_t result
);

	logic [7:0] preload_q;
	logic [7:0] count_q;
	logic [7:0] status_q;
	logic       nib_sel_q;

	logic [7:0] preload_d;
	logic [7:0] count_d;
	logic [7:0] status_d;
	logic       nib_sel_d;

	logic [2:0] region;
	logic [3:0] nibble;

	assign region = item.offset[12:10];
	assign nibble = nib_sel_q ? item.buttons[7:4] : item.buttons[3:0];

	always_comb begin
		preload_d = preload_q;
		count_d   = count_q;
		status_d  = status_q;
		nib_sel_d = nib_sel_q;
		result    = '0;
		case (iptj_pkg::op_t'(item.operation))
			iptj_pkg::OP_READ: begin
				if (region == iptj_pkg::REGION_TIMER) begin
					result.read_data = item.offset[0] ? status_q : count_q;
				end else if (region == iptj_pkg::REGION_JOYPAD) begin
					result.read_data = ~{1'b0, country, 2'b00, nibble};
				end
			end
			iptj_pkg::OP_WRITE: begin
				if (region == iptj_pkg::REGION_TIMER) begin
					if (item.offset[0]) begin
						if (!status_q[0] && item.write_data[0]) begin
							count_d = preload_q & iptj_pkg::RELOAD_MASK;
						end
						status_d = item.write_data;
					end else begin
						preload_d = item.write_data;
					end
				end else if (region == iptj_pkg::REGION_JOYPAD) begin
					nib_sel_d = item.write_data[0];
				end
			end
			iptj_pkg::OP_TICK: begin
				if (status_q[0]) begin
					if (count_q == 8'd0) begin
						count_d          = preload_q & iptj_pkg::RELOAD_MASK;
						result.timer_irq = 1'b1;
					end else begin
						count_d = count_q - 8'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preload_q <= '0;
			count_q   <= '0;
			status_q  <= '0;
			nib_sel_q <= 1'b0;
		end else if (exec) begin
			preload_q <= preload_d;
			count_q   <= count_d;
			status_q  <= status_d;
			nib_sel_q <= nib_sel_d;
		end
	end

`ifndef SYNTH
	a_count_msb: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[7] == 1'b0)
		else $error("timer count above reload range");

	a_irq_reload: assert property (@(posedge clk) disable iff (!arst_n)
		exec && result.timer_irq |=>
		count_q == ($past(preload_q) & iptj_pkg::RELOAD_MASK))
		else $error("underflow did not reload counter");

	a_irq_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		result.timer_irq |-> status_q[0] && count_q == 8'd0)
		else $error("interrupt from disabled or nonzero timer");

	a_disabled_hold: assert property (@(posedge clk) disable iff (!arst_n)
		exec && !status_q[0] && item.operation != iptj_pkg::OP_WRITE |=> $stable(count_q))
		else $error("disabled timer counter moved");
`endif

endmodule

>>> rtl/core/io_page_timer_joypad.sv
// I/O page timer and joypad port, top level.
// Input register, register/decode core and output register.
// Depends on iptj_pkg, iptj_ifs and iptj_core.
//
// One word is taken per clock while the request side is ready. Its result word
// reaches rsp through the input register, where iptj_core decodes it, and the
// output register: when the word advances, the core updates its registers and
// the output register is written at the same edge. Back-to-back words run at
// one per cycle as long as the response side keeps taking. A held response
// stalls the request side only once both registers are full. Configuration
// (country bit) is always ready and takes effect on the next executed read.
module io_page_timer_joypad (
	input  logic        clk,
	input  logic        arst_n,
	iptj_req_if.sink    req,
	iptj_rsp_if.source  rsp,
	iptj_cfg_if.sink    cfg
);

	iptj_pkg::item_t   item_s1;
	logic              valid_s1;
	iptj_pkg::result_t res_d;
	iptj_pkg::result_t res_s2;
	logic              valid_s2;
	logic              country_q;
	logic              advance;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			country_q <= 1'b1;
		end else if (cfg.valid) begin
			country_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= '{operation:  req.operation,
			             offset:     req.offset,
			             write_data: req.write_data,
			             buttons:    req.buttons};
		end
	end

	iptj_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.exec    (advance),
		.item    (item_s1),
		.country (country_q),
		.result  (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign rsp.valid     = valid_s2;
	assign rsp.read_data = res_s2.read_data;
	assign rsp.timer_irq = res_s2.timer_irq;

endmodule
